// ===== design/rwc_pkg.sv =====
package rwc_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int TEX_SIZE      = 64;
  localparam int FRAC_BITS     = 16;

  localparam int POS_FRAC = 16;
  localparam int HIT_FRAC = 28;

  localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
  localparam int LH_W      = $clog2(SCREEN_HEIGHT) + POS_FRAC + 1;
  localparam int STEP_W    = $clog2(TEX_SIZE) + FRAC_BITS + 1;
  localparam int DIV_W     = (LH_W > STEP_W) ? LH_W : STEP_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int SPAN_SW   = LH_W + 2;
  localparam int PROD_W    = SPAN_SW + STEP_W + 1;
  localparam int TEX_B     = $clog2(TEX_SIZE) + 1;
  localparam int PC_W      = 4;

  localparam logic [LH_W-1:0]  LH_MAX   = LH_W'(SCREEN_HEIGHT) << POS_FRAC;
  localparam logic [DIV_W-1:0] STEP_NUM = DIV_W'(TEX_SIZE) << FRAC_BITS;

  localparam int OUT_ROW_W = 9;
  localparam int TEXEL_W   = 6;
  localparam logic [OUT_ROW_W-1:0] LAST_ROW = OUT_ROW_W'(SCREEN_HEIGHT - 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  localparam logic [1:0] KIND_CEIL  = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_FLOOR = 2'd2;

  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_EAST  = 2'd2;
  localparam logic [1:0] TEX_WEST  = 2'd3;

  localparam logic [1:0] REG_POS_X   = 2'd0;
  localparam logic [1:0] REG_POS_Y   = 2'd1;
  localparam logic [1:0] REG_CEILING = 2'd2;
  localparam logic [1:0] REG_FLOOR   = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [9:0]         column_index;
    logic               hit_side;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [31:0]        distance;
  } req_t;

  typedef struct packed {
    logic [9:0]           out_column;
    logic [OUT_ROW_W-1:0] out_row;
    logic [1:0]           pixel_kind;
    logic [1:0]           texture_select;
    logic [TEXEL_W-1:0]   texel_u;
    logic [TEXEL_W-1:0]   texel_v;
    logic [31:0]          flat_color;
    logic                 last_row;
  } rsp_t;

  // one control word per microprogram step
  typedef struct packed {
    logic hit;       // hit product, texture choice, start divide for height
    logic texcol;    // texel column from hit fraction
    logic wait_div;  // jump to self while divider busy
    logic lh;        // capture line height
    logic span;      // draw span, start divide for step
    logic step;      // capture texel step
    logic mul_n;     // start position product
    logic accum;     // start position, column goes live
    logic last;      // return to idle
  } ctl_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '0;
    unique case (pc)
      4'd0:    c.hit      = 1'b1;
      4'd1:    c.texcol   = 1'b1;
      4'd2:    c.wait_div = 1'b1;
      4'd3:    c.lh       = 1'b1;
      4'd4:    c.span     = 1'b1;
      4'd5:    c.wait_div = 1'b1;
      4'd6:    c.step     = 1'b1;
      4'd7:    c.mul_n    = 1'b1;
      4'd8:    begin
        c.accum = 1'b1;
        c.last  = 1'b1;
      end
      default: c.last     = 1'b1;
    endcase
    return c;
  endfunction

endpackage

// ===== design/raycast_wall_column_texel_stepper.sv =====
// Load request: the shared one-bit-per-cycle divider runs twice (line
// height, then texel step). No request is taken while a load runs.
// Row request: one pixel per cycle unless the result output is stalled;
// the result is registered and valid in the cycle after accept.
// Synchronous reset clears the sequencer, the result valid flag, the active
// column flag and all four configuration registers.
module raycast_wall_column_texel_stepper
  import rwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;
  logic [PC_W-1:0] pc;
  ctl_t ctl;

  logic [31:0] pos_x, pos_y, ceiling_color, floor_color;

  req_t ld;
  logic [HIT_FRAC-1:0] hit_lo;
  logic [LH_W-1:0] lh;
  logic [9:0] cur_column;
  logic [ROW_W-1:0] row_counter, span_start, span_end;
  logic [TEXEL_W-1:0] tex_column;
  logic [1:0] tex_choice;
  logic signed [31:0] tex_row_accum;
  logic [STEP_W-1:0] tex_row_step;
  logic column_loaded;
  logic signed [PROD_W-1:0] prod_n;

  logic div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [31:0] div_rem, div_dsr;
  logic [DIV_W-1:0] div_q;
  logic [32:0] div_trial;

  logic accept, take_row;
  logic signed [HIT_FRAC:0] hit_prod_full;
  logic signed [48:0] hit_prod;
  logic [HIT_FRAC-1:0] hit_frac;
  logic [HIT_FRAC+TEX_B-1:0] tex_scaled;
  logic [TEX_B-1:0] u_raw, u_mir;
  logic mirror;
  logic signed [SPAN_SW-1:0] diff, ds_raw, de_raw, n_val;
  logic [ROW_W-1:0] ds_c, de_c;
  logic signed [PROD_W-1:0] half;
  logic signed [31:0] start_sat;
  logic [1:0] kind;
  logic [TEXEL_W-1:0] v_out;
  logic [31-FRAC_BITS:0] v_raw;
  logic signed [32:0] accum_sum;
  logic signed [31:0] accum_next;

  function automatic logic [15:0] pos_lo(input logic side, input logic [31:0] px,
                                          input logic [31:0] py);
    return (side == 1'b0) ? py[15:0] : px[15:0];
  endfunction

  assign ctl       = ucode(pc);
  assign req_ready = (state == IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign take_row  = accept && (req.opcode == OP_ROW) && column_loaded;

  // hit position fraction, only its low HIT_FRAC bits matter
  assign hit_prod = $signed({1'b0, ld.distance}) *
                    ((ld.hit_side == 1'b0) ? ld.dir_y : ld.dir_x);
  assign hit_prod_full = hit_prod[HIT_FRAC:0];
  assign hit_frac = hit_lo;
  assign tex_scaled = (HIT_FRAC+TEX_B)'(hit_frac) * (HIT_FRAC+TEX_B)'(TEX_SIZE);
  assign u_raw  = tex_scaled[HIT_FRAC +: TEX_B];
  assign u_mir  = TEX_B'(TEX_SIZE) - u_raw - TEX_B'(1);
  assign mirror = ((ld.hit_side == 1'b0) && ld.dir_x[15]) ||
                  ((ld.hit_side == 1'b1) && !ld.dir_y[15] && (ld.dir_y != '0));

  // draw span, start truncated toward zero
  assign diff   = SPAN_SW'(SCREEN_HEIGHT) - SPAN_SW'(lh);
  assign ds_raw = diff[SPAN_SW-1] ? -((-diff) >>> 1) : (diff >>> 1);
  assign de_raw = ds_raw + SPAN_SW'(lh) - SPAN_SW'(1);
  assign ds_c   = ds_raw[SPAN_SW-1] ? '0 : ds_raw[ROW_W-1:0];
  assign de_c   = (de_raw >= SPAN_SW'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                      : de_raw[ROW_W-1:0];
  assign n_val  = (SPAN_SW'(span_start) <<< 1) - SPAN_SW'(SCREEN_HEIGHT) + SPAN_SW'(lh);

  assign half = prod_n >>> 1;
  always_comb begin
    if (half > PROD_W'(64'sd2147483647)) start_sat = 32'sh7fffffff;
    else if (half < -PROD_W'(64'sd2147483648)) start_sat = 32'sh80000000;
    else start_sat = half[31:0];
  end

  assign div_trial = {div_rem, div_q[DIV_W-1]};

  // row pixel
  always_comb begin
    if (row_counter < span_start) kind = KIND_CEIL;
    else if (row_counter <= span_end) kind = KIND_WALL;
    else kind = KIND_FLOOR;
    v_raw = tex_row_accum[31:FRAC_BITS];
    if (tex_row_accum[31]) v_out = '0;
    else if (v_raw > (32-FRAC_BITS)'(TEX_SIZE - 1)) v_out = TEXEL_W'(TEX_SIZE - 1);
    else v_out = v_raw[TEXEL_W-1:0];
    accum_sum = 33'(tex_row_accum) + $signed({1'b0, 32'(tex_row_step)});
    accum_next = (accum_sum > 33'sh07fffffff) ? 32'sh7fffffff : accum_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      pc            <= '0;
      rsp_valid     <= 1'b0;
      column_loaded <= 1'b0;
      div_busy      <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      ceiling_color <= '0;
      floor_color   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_POS_X:   pos_x <= cfg_data;
          REG_POS_Y:   pos_y <= cfg_data;
          REG_CEILING: ceiling_color <= cfg_data;
          REG_FLOOR:   floor_color <= cfg_data;
          default:     ;
        endcase
      end

      if (rsp_valid && rsp_ready && !take_row) rsp_valid <= 1'b0;

      unique case (state)
        IDLE: begin
          if (accept && req.opcode == OP_LOAD) begin
            ld            <= req;
            state         <= RUN;
            pc            <= '0;
            column_loaded <= 1'b0;
          end else if (take_row) begin
            rsp_valid          <= 1'b1;
            rsp.out_column     <= cur_column;
            rsp.out_row        <= OUT_ROW_W'(row_counter);
            rsp.pixel_kind     <= kind;
            rsp.texture_select <= (kind == KIND_WALL) ? tex_choice : '0;
            rsp.texel_u        <= (kind == KIND_WALL) ? tex_column : '0;
            rsp.texel_v        <= (kind == KIND_WALL) ? v_out : '0;
            rsp.flat_color     <= (kind == KIND_CEIL) ? ceiling_color :
                                  (kind == KIND_FLOOR) ? floor_color : '0;
            rsp.last_row       <= (row_counter >= ROW_W'(SCREEN_HEIGHT - 1));
            if (kind == KIND_WALL) tex_row_accum <= accum_next;
            if (row_counter >= ROW_W'(SCREEN_HEIGHT - 1)) column_loaded <= 1'b0;
            row_counter <= row_counter + ROW_W'(1);
          end
        end
        RUN: begin
          if (ctl.hit) begin
            hit_lo     <= hit_prod_full[HIT_FRAC-1:0] +
                          {pos_lo(ld.hit_side, pos_x, pos_y), 12'b0};
            cur_column <= ld.column_index;
            if (ld.hit_side == 1'b0) tex_choice <= ld.dir_x[15] || ld.dir_x == '0 ?
                                                   TEX_WEST : TEX_EAST;
            else tex_choice <= (!ld.dir_y[15] && ld.dir_y != '0) ? TEX_SOUTH : TEX_NORTH;
            div_busy <= 1'b1;
            div_cnt  <= DIV_CNT_W'(DIV_W);
            div_rem  <= '0;
            div_q    <= DIV_W'(LH_MAX);
            div_dsr  <= ld.distance;
          end
          if (ctl.texcol) tex_column <= mirror ? u_mir[TEXEL_W-1:0] : u_raw[TEXEL_W-1:0];
          if (ctl.lh) lh <= (ld.distance == '0) ? LH_MAX : div_q[LH_W-1:0];
          if (ctl.span) begin
            span_start <= ds_c;
            span_end   <= de_c;
            div_busy   <= 1'b1;
            div_cnt    <= DIV_CNT_W'(DIV_W);
            div_rem    <= '0;
            div_q      <= STEP_NUM;
            div_dsr    <= 32'(lh);
          end
          if (ctl.step) tex_row_step <= (lh == '0) ? '0 : div_q[STEP_W-1:0];
          if (ctl.mul_n) prod_n <= n_val * $signed({1'b0, tex_row_step});
          if (ctl.accum) begin
            tex_row_accum <= start_sat;
            row_counter   <= '0;
            column_loaded <= 1'b1;
          end
          if (ctl.last) state <= IDLE;
          else if (!(ctl.wait_div && div_busy)) pc <= pc + PC_W'(1);
        end
        default: state <= IDLE;
      endcase

      // restoring divider, one quotient bit per cycle
      if (div_busy && !ctl.hit && !ctl.span) begin
        if (div_trial >= {1'b0, div_dsr}) begin
          div_rem <= 32'(div_trial - {1'b0, div_dsr});
          div_q   <= {div_q[DIV_W-2:0], 1'b1};
        end else begin
          div_rem <= div_trial[31:0];
          div_q   <= {div_q[DIV_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt - DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(1)) div_busy <= 1'b0;
      end
    end
  end

endmodule

// ===== design/rwc_checker.sv =====
module rwc_checker
  import rwc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.pixel_kind == KIND_CEIL || rsp.pixel_kind == KIND_WALL ||
                  rsp.pixel_kind == KIND_FLOOR)
    else $error("bad pixel kind");

  a_wall_flat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pixel_kind == KIND_WALL |-> rsp.flat_color == '0)
    else $error("wall pixel carries a flat color");

  a_flat_tex: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pixel_kind != KIND_WALL |->
      rsp.texel_u == '0 && rsp.texel_v == '0 && rsp.texture_select == '0)
    else $error("flat pixel carries texel fields");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.last_row == (rsp.out_row == LAST_ROW))
    else $error("last row flag mismatch");

endmodule

bind raycast_wall_column_texel_stepper rwc_checker u_rwc_checker (.*);
